// ===== src/quadratic_probe_hash_table_macros.svh =====
// Assertion helpers used by the asserting module.
`ifndef QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH

// Checks that an implication holds on every clock edge outside reset.
`define QPHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition holds in the cycle after an antecedent.
`define QPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/qpht_pkg.sv =====
package qpht_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned KeyChars   = 10;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned SizeW      = IdxW + 1;

  localparam int unsigned EntryW = 64 + 16 + 4 + 64 + 16 + 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  typedef struct packed {
    logic [63:0] key_low;
    logic [15:0] key_high;
    logic [3:0]  key_len;
    logic [63:0] name_low;
    logic [15:0] name_high;
    logic [31:0] mean;
  } entry_t;
endpackage

// ===== src/quadratic_probe_hash_table.sv =====
// Channel   | Direction | Signals
// request   | in        | start, op_i, key_*_i, name_*_i, mean_bits_i (busy is out)
// result    | out       | done_o, status_o .. found_mean_bits_o (one cycle)
// config    | in        | cfg_valid_i, cfg_data_i (table_size); cfg_ready_o is out
//
// A request hashes its key with a multiply, then nine shift-and-subtract remainder
// steps per key character, and a final step takes the home slot. Each probe computes
// the slot index, reads the slot memory, then checks the slot and updates the step.
// Clear writes the 1024 used-flags, one per cycle. Every request ends with one result
// cycle. After reset a clearing pass of all 1024 used-flags runs with busy high. The
// result strobe cannot be stalled; busy stays high until the result cycle has passed.
`include "quadratic_probe_hash_table_macros.svh"
module quadratic_probe_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [63:0] key_low_i,
  input  logic [15:0] key_high_i,
  input  logic [3:0]  key_len_i,
  input  logic [63:0] name_low_i,
  input  logic [15:0] name_high_i,
  input  logic [31:0] mean_bits_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [10:0] probes_o,
  output logic [9:0]  slot_index_o,
  output logic [9:0]  home_slot_o,
  output logic [63:0] found_name_low_o,
  output logic [15:0] found_name_high_o,
  output logic [31:0] found_mean_bits_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);
  import qpht_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_HMUL, S_HMOD, S_PIDX, S_PRD, S_PCHK, S_DONE
  } state_e;

  localparam int unsigned ProdW = SizeW + 8;

  state_e           state_q;
  logic [SizeW-1:0] size_cfg_q;
  logic [SizeW-1:0] size_q;
  logic [1:0]       op_q;
  logic [63:0]      klo_q;
  logic [15:0]      khi_q;
  logic [3:0]       len_q;
  logic [63:0]      nlo_q;
  logic [15:0]      nhi_q;
  logic [31:0]      mean_q;
  logic [3:0]       ci_q;
  logic [ProdW-1:0] rem_q;
  logic [3:0]       rbit_q;
  logic [IdxW-1:0]  home_q;
  logic [SizeW-1:0] step_q;
  logic [SizeW-1:0] sq_q;     // step squared mod size
  logic [IdxW-1:0]  idx_q;
  logic [IdxW:0]    clr_q;
  logic             done_q;
  logic [2:0]       status_q;
  logic [10:0]      probes_q;
  logic [9:0]       slot_q;
  logic [9:0]       home_slot_q;
  logic [63:0]      fnlo_q;
  logic [15:0]      fnhi_q;
  logic [31:0]      fmean_q;

  logic             used_we, used_wd, used_rd;
  logic [IdxW-1:0]  used_wa, used_ra;
  logic             ent_we;
  entry_t           ent_wd, ent_rd;

  qpht_ram #(.Width(1), .Depth(TableDepth)) u_used (
    .clk_i(clk_i), .we_i(used_we), .waddr_i(used_wa), .wdata_i(used_wd),
    .raddr_i(used_ra), .rdata_o(used_rd)
  );
  qpht_ram #(.Width(EntryW), .Depth(TableDepth)) u_entry (
    .clk_i(clk_i), .we_i(ent_we), .waddr_i(idx_q), .wdata_i(ent_wd),
    .raddr_i(used_ra), .rdata_o(ent_rd)
  );

  // Masking of key characters past the length.
  logic [3:0]  len_in;
  logic [63:0] lmask;
  logic [15:0] hmask;
  always_comb begin
    len_in = (key_len_i > 4'(KeyChars)) ? 4'(KeyChars) : key_len_i;
    lmask = '0;
    for (int i = 0; i < 8; i++) begin
      if (32'(len_in) >= 32'(i + 3)) lmask[63-8*i -: 8] = 8'hFF;
    end
    hmask = {(len_in >= 4'd1) ? 8'hFF : 8'h00, (len_in >= 4'd2) ? 8'hFF : 8'h00};
  end

  logic [SizeW-1:0] size_eff;
  always_comb begin
    if (size_cfg_q == '0) size_eff = SizeW'(1);
    else if (size_cfg_q > SizeW'(TableDepth)) size_eff = SizeW'(TableDepth);
    else size_eff = size_cfg_q;
  end

  logic [7:0] chr;
  always_comb begin
    unique case (ci_q)
      4'd0:    chr = khi_q[15:8];
      4'd1:    chr = khi_q[7:0];
      default: chr = klo_q[8*(4'd9-ci_q) +: 8];
    endcase
  end

  // Remainder by shift-and-subtract, one quotient bit a cycle.
  logic [ProdW-1:0] sub_v;
  assign sub_v = {size_q, 8'd0} >> rbit_q;

  logic [SizeW:0] idx_sum, sq_next;
  logic [SizeW:0] stp2;
  assign idx_sum = {1'b0, 1'b0, home_q} + {1'b0, sq_q};
  // (s+1)^2 = s^2 + 2s + 1, with 2s+1 reduced mod size.
  logic [SizeW+1:0] inc_raw;
  logic [SizeW+1:0] inc_m;
  logic [SizeW+1:0] sq_raw;
  always_comb begin
    inc_raw = {1'b0, step_q, 1'b1};
    inc_m = inc_raw;
    if (inc_m >= {2'b0, size_q}) inc_m = inc_m - {2'b0, size_q};
    if (inc_m >= {2'b0, size_q}) inc_m = inc_m - {2'b0, size_q};
    sq_raw = {2'b0, sq_q} + inc_m;
    if (sq_raw >= {2'b0, size_q}) sq_raw = sq_raw - {2'b0, size_q};
    sq_next = sq_raw[SizeW:0];
    stp2 = idx_sum;
    if (stp2 >= {1'b0, size_q}) stp2 = stp2 - {1'b0, size_q};
  end

  logic key_eq;
  assign key_eq = (ent_rd.key_len == len_q) && (ent_rd.key_low == klo_q)
                  && (ent_rd.key_high == khi_q);

  always_comb begin
    used_we = 1'b0;
    used_wa = idx_q;
    used_wd = 1'b0;
    used_ra = idx_q;
    ent_we  = 1'b0;
    ent_wd  = '{key_low: klo_q, key_high: khi_q, key_len: len_q,
                name_low: nlo_q, name_high: nhi_q, mean: mean_q};
    if (state_q == S_INIT || state_q == S_CLEAR) begin
      used_we = 1'b1;
      used_wa = clr_q[IdxW-1:0];
    end else if (state_q == S_PCHK && !used_rd && op_q == OP_INSERT) begin
      used_we = 1'b1;
      used_wd = 1'b1;
      ent_we  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      size_cfg_q <= SizeW'(1021);
      clr_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) size_cfg_q <= cfg_data_i;
      unique case (state_q)
        S_INIT, S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (IdxW+1)'(TableDepth - 1)) begin
            clr_q <= '0;
            if (state_q == S_CLEAR) begin
              done_q   <= 1'b1;
              status_q <= ST_CLEARED;
              probes_q <= '0;
              slot_q   <= '0;
              home_slot_q <= '0;
              fnlo_q <= '0; fnhi_q <= '0; fmean_q <= '0;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (start && op_i != OP_NONE) begin
            op_q   <= op_i;
            klo_q  <= key_low_i & lmask;
            khi_q  <= key_high_i & hmask;
            len_q  <= len_in;
            nlo_q  <= name_low_i;
            nhi_q  <= name_high_i;
            mean_q <= mean_bits_i;
            size_q <= size_eff;
            ci_q   <= '0;
            rem_q  <= (size_eff == SizeW'(1)) ? '0 : ProdW'(1);
            if (op_i == OP_CLEAR) state_q <= S_CLEAR;
            else state_q <= S_HMUL;
          end
        end
        S_HMUL: begin
          if (ci_q == len_q) begin
            home_q  <= rem_q[IdxW-1:0];
            step_q  <= '0;
            sq_q    <= '0;
            state_q <= S_PIDX;
          end else begin
            rem_q   <= ProdW'(rem_q[SizeW-1:0]) * ProdW'(chr);
            rbit_q  <= '0;
            state_q <= S_HMOD;
          end
        end
        S_HMOD: begin
          if (rem_q >= sub_v) rem_q <= rem_q - sub_v;
          rbit_q <= rbit_q + 1'b1;
          if (rbit_q == 4'd8) begin
            ci_q    <= ci_q + 1'b1;
            state_q <= S_HMUL;
          end
        end
        S_PIDX: begin
          idx_q   <= stp2[IdxW-1:0];
          state_q <= S_PRD;
        end
        S_PRD: state_q <= S_PCHK;
        S_PCHK: begin
          home_slot_q <= home_q;
          fnlo_q <= '0; fnhi_q <= '0; fmean_q <= '0;
          slot_q <= '0;
          probes_q <= step_q + 1'b1;
          if (!used_rd) begin
            done_q <= 1'b1;
            state_q <= S_DONE;
            if (op_q == OP_INSERT) begin
              status_q <= ST_INSERTED;
              slot_q   <= idx_q;
            end else begin
              status_q <= ST_NOT_FOUND;
            end
          end else if (op_q == OP_SEARCH && key_eq) begin
            done_q   <= 1'b1;
            state_q  <= S_DONE;
            status_q <= ST_FOUND;
            slot_q   <= idx_q;
            fnlo_q   <= ent_rd.name_low;
            fnhi_q   <= ent_rd.name_high;
            fmean_q  <= ent_rd.mean;
          end else if (step_q + 1'b1 == size_q) begin
            done_q   <= 1'b1;
            state_q  <= S_DONE;
            status_q <= (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
            probes_q <= size_q;
          end else begin
            step_q  <= step_q + 1'b1;
            sq_q    <= sq_next[SizeW-1:0];
            state_q <= S_PIDX;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign cfg_ready_o       = (state_q == S_IDLE) && !start;
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign probes_o          = probes_q;
  assign slot_index_o      = slot_q;
  assign home_slot_o       = home_slot_q;
  assign found_name_low_o  = fnlo_q;
  assign found_name_high_o = fnhi_q;
  assign found_mean_bits_o = fmean_q;

  `QPHT_ASSERT_IMP(a_done_state, clk_i, rst_ni, done_q, state_q == S_DONE)
  `QPHT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy && op_i != OP_NONE, busy)
  `QPHT_ASSERT_IMP(a_probe_bound, clk_i, rst_ni, state_q == S_PCHK, step_q < size_q)
endmodule

// ===== src/qpht_ram.sv =====
module qpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
